// ===== rtl/xss_pkg.sv =====
package xss_pkg;

	localparam int unsigned WordW   = 64;
	localparam int unsigned NumWords = 8;
	localparam int unsigned IdxW    = 3;

	localparam int unsigned ShiftAmt  = 11;
	localparam int unsigned RotAmt    = 21;
	localparam int unsigned RotOutAmt = 7;

	// operation codes
	localparam logic OP_GEN  = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	typedef logic [WordW-1:0] word_t;

	typedef struct packed {
		logic load;   // write one state word
		logic step;   // advance state, capture scrambler first half
		logic fin;    // finish scrambler into output register
	} cmd_t;

	function automatic word_t rotl(input word_t x, input int unsigned k);
		rotl = (x << k) | (x >> (WordW - k));
	endfunction

endpackage

// ===== rtl/xss_dpath.sv =====
module xss_dpath (
	input  logic                      clk,
	input  xss_pkg::cmd_t             cmd,
	input  logic [xss_pkg::IdxW-1:0]  word_index,
	input  xss_pkg::word_t            load_value,
	output xss_pkg::word_t            random_word
);

	xss_pkg::word_t st_q [xss_pkg::NumWords];
	xss_pkg::word_t mul5_q;
	xss_pkg::word_t out_q;
	xss_pkg::word_t nxt [xss_pkg::NumWords];
	xss_pkg::word_t w1;
	xss_pkg::word_t s2x;
	xss_pkg::word_t s5x;
	xss_pkg::word_t s7x;

	// xoshiro512 state advance, written against the old words
	always_comb begin
		w1  = st_q[1];
		s2x = st_q[2] ^ st_q[0];
		s5x = st_q[5] ^ w1;
		s7x = st_q[7] ^ st_q[3];
		nxt[0] = st_q[0] ^ st_q[6];
		nxt[1] = w1 ^ s2x;
		nxt[2] = s2x;
		nxt[3] = st_q[3] ^ st_q[4];
		nxt[4] = st_q[4] ^ s5x;
		nxt[5] = s5x;
		nxt[6] = st_q[6] ^ s7x ^ (w1 << xss_pkg::ShiftAmt);
		nxt[7] = xss_pkg::rotl(s7x, xss_pkg::RotAmt);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			st_q[word_index] <= load_value;
		end else if (cmd.step) begin
			for (int i = 0; i < xss_pkg::NumWords; i++) begin
				st_q[i] <= nxt[i];
			end
		end
	end

	// scrambler: rotl(w1*5, 7) held, then *9 when the finish command comes
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			mul5_q <= xss_pkg::rotl(w1 + (w1 << 2), xss_pkg::RotOutAmt);
		end
		if (cmd.fin) begin
			out_q <= mul5_q + (mul5_q << 3);
		end
	end

	assign random_word = out_q;

endmodule

// ===== rtl/xss_ctrl.sv =====
module xss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          operation,
	output logic          out_valid,
	input  logic          out_ready,
	output xss_pkg::cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_FIN  = 1'b1;

	logic state_q;
	logic state_nxt;
	logic out_valid_q;
	logic accept;
	logic out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;

	assign cmd.load = accept & (operation == xss_pkg::OP_LOAD);
	assign cmd.step = accept & (operation == xss_pkg::OP_GEN);
	assign cmd.fin  = (state_q == ST_FIN) & out_free;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.step) state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (cmd.fin) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.step))
		else $error("load and step together");

	a_step_fin: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (state_q == ST_FIN) && !in_ready)
		else $error("step did not enter finish state");

	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> out_valid_q && (state_q == ST_IDLE))
		else $error("finish did not present a word");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !out_valid_q || out_ready)
		else $error("output word overwritten before taken");

endmodule

// ===== rtl/xoshiro512_starstar_generator.sv =====
// channel | signals                                   | dir | accepted when
// input   | in_valid/in_ready, operation, word_index, | in  | in_valid & in_ready
//         | load_value                                |     |
// output  | out_valid/out_ready, random_word          | out | out_valid & out_ready
//
// A load writes one state word. A generate first advances the state and registers
// rotl(w1*5,7), then the *9 add fills the output register.
// A finished word waits in the output register; new input is taken meanwhile.
// A generate stalls in its finish state only while the output register is full.
// Reset clears control only; state words are undefined until loaded.
module xoshiro512_starstar_generator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      operation,
	input  logic [xss_pkg::IdxW-1:0]  word_index,
	input  logic [63:0]               load_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [63:0]               random_word
);

	xss_pkg::cmd_t cmd;

	xss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	xss_dpath u_dpath (
		.clk         (clk),
		.cmd         (cmd),
		.word_index  (word_index),
		.load_value  (load_value),
		.random_word (random_word)
	);

endmodule
